### hdl/psh_pkg.sv
// ----------------------------------------------------------------------------
// Phong pixel shading package
// Shared widths, pipeline lengths and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package psh_pkg;

    localparam int SQRT_STEPS = 18;
    localparam int DIV_STEPS  = 15;
    localparam int NORM_LAT   = 36;
    localparam int E_DLY      = NORM_LAT + 4;
    localparam int DF_DLY     = NORM_LAT + 9;
    localparam int PIPE_LAST  = 2 * NORM_LAT + 16;
    localparam int TEX_LAST   = PIPE_LAST - 2;
    localparam int SPEC_SQ    = 4;

    localparam logic [14:0] UNIT_Q14 = 15'd16384;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 48;

    localparam logic [CFG_AW-1:0] CFG_LIGHT_POS = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_EYE_POS   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_AMBIENT   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_LIGHT_COL = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_KD        = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_KS        = 3'd5;

    localparam logic [15:0] COEF_RESET = 16'd4096;

    typedef logic signed [17:0] t_comp;
    typedef logic signed [15:0] t_unit;
    typedef logic [15:0]        t_chan;

endpackage

`default_nettype wire

### hdl/psh_norm.sv
// ----------------------------------------------------------------------------
// Vector normaliser
// Pipelined sum of squares, bit-per-stage square root and a restoring
// divider giving three signed Q2.14 unit components.
// ----------------------------------------------------------------------------
`default_nettype none

module psh_norm
    import psh_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_ce,
    input  t_comp i_vec  [3],
    output t_unit o_unit [3]
);

    logic signed [35:0] n_sq [3];
    logic [34:0]        r_sq [3];
    t_comp              r_v1 [3];
    logic [35:0]        n_sum;

    logic [35:0] r_rem [SQRT_STEPS+1];
    logic [35:0] r_res [SQRT_STEPS+1];
    t_comp       r_vs  [SQRT_STEPS+1][3];
    logic [36:0] n_trial [SQRT_STEPS];
    logic [35:0] n_rem   [SQRT_STEPS];
    logic [35:0] n_res   [SQRT_STEPS];

    logic [17:0] n_mag  [3];
    logic [18:0] n_dsh  [DIV_STEPS][3];
    logic        n_dge  [DIV_STEPS][3];
    logic [17:0] n_drem [DIV_STEPS][3];
    logic [14:0] n_dq   [DIV_STEPS][3];

    logic [17:0] r_drem [DIV_STEPS][3];
    logic [14:0] r_dq   [DIV_STEPS][3];
    logic        r_dsg  [DIV_STEPS][3];
    logic [17:0] r_ddiv [DIV_STEPS];
    logic        r_dz   [DIV_STEPS];

    logic [14:0] n_qc [3];
    t_unit       r_out [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_sq[c] = i_vec[c] * i_vec[c];
        end
        n_sum = 36'(r_sq[0]) + 36'(r_sq[1]) + 36'(r_sq[2]);
    end

    // One result bit per stage, the test bit walking down two places at a time.
    always_comb begin
        for (int k = 0; k < SQRT_STEPS; k++) begin
            n_trial[k] = {1'b0, r_res[k]} + (37'd1 << (2 * (SQRT_STEPS - 1 - k)));
            if ({1'b0, r_rem[k]} >= n_trial[k]) begin
                n_rem[k] = r_rem[k] - n_trial[k][35:0];
                n_res[k] = (r_res[k] >> 1) + 36'(37'd1 << (2 * (SQRT_STEPS - 1 - k)));
            end else begin
                n_rem[k] = r_rem[k];
                n_res[k] = r_res[k] >> 1;
            end
        end
    end

    // The quotient never exceeds one unit, so the divider starts with the
    // magnitude itself as the first partial remainder.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_mag[c] = r_vs[SQRT_STEPS][c][17] ? 18'(-r_vs[SQRT_STEPS][c])
                                               : 18'(r_vs[SQRT_STEPS][c]);
            n_dsh[0][c]  = {1'b0, n_mag[c]};
            n_dge[0][c]  = n_dsh[0][c] >= {1'b0, r_res[SQRT_STEPS][17:0]};
            n_drem[0][c] = n_dge[0][c] ? 18'(n_dsh[0][c] - {1'b0, r_res[SQRT_STEPS][17:0]})
                                       : n_dsh[0][c][17:0];
            n_dq[0][c]   = {14'd0, n_dge[0][c]};
            for (int j = 1; j < DIV_STEPS; j++) begin
                n_dsh[j][c]  = {r_drem[j-1][c], 1'b0};
                n_dge[j][c]  = n_dsh[j][c] >= {1'b0, r_ddiv[j-1]};
                n_drem[j][c] = n_dge[j][c] ? 18'(n_dsh[j][c] - {1'b0, r_ddiv[j-1]})
                                           : n_dsh[j][c][17:0];
                n_dq[j][c]   = {r_dq[j-1][c][13:0], n_dge[j][c]};
            end
            if (r_dz[DIV_STEPS-1]) begin
                n_qc[c] = '0;
            end else if (r_dq[DIV_STEPS-1][c] > UNIT_Q14) begin
                n_qc[c] = UNIT_Q14;
            end else begin
                n_qc[c] = r_dq[DIV_STEPS-1][c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int c = 0; c < 3; c++) begin
                r_sq[c] <= n_sq[c][34:0];
                r_v1[c] <= i_vec[c];
            end
            r_rem[0] <= n_sum;
            r_res[0] <= '0;
            r_vs[0]  <= r_v1;
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_res[k+1] <= n_res[k];
                r_vs[k+1]  <= r_vs[k];
            end
            r_ddiv[0] <= r_res[SQRT_STEPS][17:0];
            r_dz[0]   <= (r_res[SQRT_STEPS] == '0);
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_ddiv[j] <= r_ddiv[j-1];
                r_dz[j]   <= r_dz[j-1];
            end
            for (int c = 0; c < 3; c++) begin
                r_dsg[0][c] <= r_vs[SQRT_STEPS][c][17];
                for (int j = 1; j < DIV_STEPS; j++) begin
                    r_dsg[j][c] <= r_dsg[j-1][c];
                end
                for (int j = 0; j < DIV_STEPS; j++) begin
                    r_drem[j][c] <= n_drem[j][c];
                    r_dq[j][c]   <= n_dq[j][c];
                end
                r_out[c] <= r_dsg[DIV_STEPS-1][c] ? -$signed({1'b0, n_qc[c]})
                                                  : $signed({1'b0, n_qc[c]});
            end
        end
    end

    assign o_unit = r_out;

endmodule

`default_nettype wire

### hdl/phong_pixel_shading_unit.sv
// ----------------------------------------------------------------------------
// Phong pixel shading unit
// Per-pixel ambient, diffuse and specular lighting of a texel colour.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle; the whole pipeline advances together and
// holds while a result waits at the output.
// The depth comes from two normalisers in series (18 square root steps and
// 15 divide steps each). Synchronous reset clears the valid bits and loads
// the register reset values.
`default_nettype none

module phong_pixel_shading_unit
    import psh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic signed [15:0] i_world_x,
    input  logic signed [15:0] i_world_y,
    input  logic signed [15:0] i_world_z,
    input  logic [15:0]        i_texel_red,
    input  logic [15:0]        i_texel_green,
    input  logic [15:0]        i_texel_blue,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [15:0]        o_shaded_red,
    output logic [15:0]        o_shaded_green,
    output logic [15:0]        o_shaded_blue,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata
);

    logic [CFG_DW-1:0] r_light_pos, r_eye_pos, r_ambient, r_light_col;
    logic [15:0]       r_kd, r_ks;

    logic adv;
    logic r_vld [PIPE_LAST+1];

    t_unit nrm_in [3];
    t_unit wld_in [3];
    t_chan tex_in [3];
    t_comp n_nv [3], n_lv [3], n_ev [3];
    t_comp r_nv [3], r_lv [3], r_ev [3];
    t_chan r_tex [TEX_LAST+1][3];

    t_unit w_n [3], w_l [3], w_e [3], w_r [3];

    logic signed [31:0] n_pnl [3];
    logic signed [31:0] r_pnl [3];
    t_unit              r_n37 [3], r_l37 [3], r_n38 [3], r_l38 [3], r_l39 [3];
    logic signed [33:0] n_dsum;
    logic signed [33:0] n_dsh;
    t_comp              r_d;
    logic [14:0]        n_diff;
    logic signed [35:0] n_prod [3];
    logic signed [35:0] r_prv [3];
    logic signed [35:0] n_rv [3];
    t_comp              r_rv [3];

    t_unit              r_edl [E_DLY][3];
    logic [14:0]        r_dfd [DF_DLY];
    logic signed [31:0] n_per [3];
    logic signed [31:0] r_per [3];
    logic signed [33:0] n_ssum;
    logic signed [33:0] n_sdot;
    logic [14:0]        r_spec [SPEC_SQ+1];
    logic [29:0]        n_ssq [SPEC_SQ];
    logic [30:0]        n_tkd, n_tks;
    logic [30:0]        r_tkd, r_tks;
    logic [31:0]        n_tsum;
    logic [21:0]        r_term;
    logic [37:0]        n_plit [3];
    logic [37:0]        r_plit [3];
    logic [22:0]        r_lit [3];
    logic [38:0]        n_pcol [3];
    logic [38:0]        r_pcol [3];
    logic [15:0]        r_out [3];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_pos <= '0;
            r_eye_pos   <= '0;
            r_ambient   <= '0;
            r_light_col <= '0;
            r_kd        <= COEF_RESET;
            r_ks        <= COEF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_LIGHT_POS: r_light_pos <= i_cfg_wdata;
                CFG_EYE_POS:   r_eye_pos   <= i_cfg_wdata;
                CFG_AMBIENT:   r_ambient   <= i_cfg_wdata;
                CFG_LIGHT_COL: r_light_col <= i_cfg_wdata;
                CFG_KD:        r_kd        <= i_cfg_wdata[15:0];
                CFG_KS:        r_ks        <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    assign adv        = i_out_ready | ~r_vld[PIPE_LAST];
    assign o_in_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= PIPE_LAST; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[0] <= i_in_valid;
            for (int s = 1; s <= PIPE_LAST; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    assign nrm_in = '{i_normal_x, i_normal_y, i_normal_z};
    assign wld_in = '{i_world_x, i_world_y, i_world_z};
    assign tex_in = '{i_texel_red, i_texel_green, i_texel_blue};

    // Light vector is world minus light, eye vector is eye minus world.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_nv[c] = t_comp'(nrm_in[c]);
            n_lv[c] = t_comp'(wld_in[c]) - t_comp'($signed(r_light_pos[16*c +: 16]));
            n_ev[c] = t_comp'($signed(r_eye_pos[16*c +: 16])) - t_comp'(wld_in[c]);
        end
    end

    psh_norm u_norm_n (.i_clk(i_clk), .i_ce(adv), .i_vec(r_nv), .o_unit(w_n));
    psh_norm u_norm_l (.i_clk(i_clk), .i_ce(adv), .i_vec(r_lv), .o_unit(w_l));
    psh_norm u_norm_e (.i_clk(i_clk), .i_ce(adv), .i_vec(r_ev), .o_unit(w_e));
    psh_norm u_norm_r (.i_clk(i_clk), .i_ce(adv), .i_vec(r_rv), .o_unit(w_r));

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_pnl[c]  = w_n[c] * w_l[c];
            n_prod[c] = r_d * r_n38[c];
            n_rv[c]   = (r_prv[c] >>> 14) - r_l39[c];
            n_per[c]  = r_edl[E_DLY-1][c] * w_r[c];
            n_plit[c] = 38'(r_light_col[16*c +: 16]) * 38'(r_term);
            n_pcol[c] = 39'(r_tex[TEX_LAST][c]) * 39'(r_lit[c]);
        end
        n_dsum = 34'(r_pnl[0]) + 34'(r_pnl[1]) + 34'(r_pnl[2]);
        n_dsh  = n_dsum >>> 14;
        if (n_dsh < 0) begin
            n_diff = (-n_dsh > 34'sd16384) ? UNIT_Q14 : 15'(-n_dsh);
        end else begin
            n_diff = (n_dsh > 34'sd16384) ? UNIT_Q14 : 15'(n_dsh);
        end
        n_ssum = 34'(r_per[0]) + 34'(r_per[1]) + 34'(r_per[2]);
        n_sdot = n_ssum >>> 14;
        for (int k = 0; k < SPEC_SQ; k++) begin
            n_ssq[k] = 30'(r_spec[k]) * 30'(r_spec[k]);
        end
        n_tkd  = 31'(r_dfd[DF_DLY-1]) * 31'(r_kd);
        n_tks  = 31'(r_spec[SPEC_SQ]) * 31'(r_ks);
        n_tsum = 32'(r_tkd) + 32'(r_tks);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_nv <= n_nv;
            r_lv <= n_lv;
            r_ev <= n_ev;
            r_tex[0] <= tex_in;
            for (int s = 1; s <= TEX_LAST; s++) begin
                r_tex[s] <= r_tex[s-1];
            end

            // Diffuse dot product and reflected vector.
            r_pnl <= n_pnl;
            r_n37 <= w_n;
            r_l37 <= w_l;
            r_d    <= n_dsh[17:0];
            r_n38  <= r_n37;
            r_l38  <= r_l37;
            r_dfd[0] <= n_diff;
            for (int s = 1; s < DF_DLY; s++) begin
                r_dfd[s] <= r_dfd[s-1];
            end
            for (int c = 0; c < 3; c++) begin
                r_prv[c] <= {n_prod[c][34:0], 1'b0};
                r_rv[c]  <= n_rv[c][17:0];
            end
            r_l39 <= r_l38;

            // Specular dot product, clamped between zero and one unit and raised to the 16th.
            r_edl[0] <= w_e;
            for (int s = 1; s < E_DLY; s++) begin
                r_edl[s] <= r_edl[s-1];
            end
            r_per <= n_per;
            if (n_sdot < 0) begin
                r_spec[0] <= '0;
            end else if (n_sdot > 34'sd16384) begin
                r_spec[0] <= UNIT_Q14;
            end else begin
                r_spec[0] <= n_sdot[14:0];
            end
            for (int k = 0; k < SPEC_SQ; k++) begin
                r_spec[k+1] <= n_ssq[k][28:14];
            end

            // Lighting term and colour.
            r_tkd  <= n_tkd;
            r_tks  <= n_tks;
            r_term <= n_tsum[31:10];
            for (int c = 0; c < 3; c++) begin
                r_plit[c] <= n_plit[c];
                r_lit[c]  <= 23'(r_ambient[16*c +: 16]) + 23'(r_plit[c][37:16]);
                r_pcol[c] <= n_pcol[c];
                r_out[c]  <= (r_pcol[c][38:32] != '0) ? 16'hFFFF : r_pcol[c][31:16];
            end
        end
    end

    assign o_out_valid    = r_vld[PIPE_LAST];
    assign o_shaded_red   = r_out[0];
    assign o_shaded_green = r_out[1];
    assign o_shaded_blue  = r_out[2];

endmodule

`default_nettype wire

### tb/phong_pixel_shading_checker.sv
// ----------------------------------------------------------------------------
// Phong pixel shading checker
// Watches the pixel, result and register ports, predicts the lit colour of
// every accepted request and compares it with the results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module phong_pixel_shading_checker
    import psh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic signed [15:0] i_world_x,
    input  logic signed [15:0] i_world_y,
    input  logic signed [15:0] i_world_z,
    input  logic [15:0]        i_texel_red,
    input  logic [15:0]        i_texel_green,
    input  logic [15:0]        i_texel_blue,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [15:0]        i_shaded_red,
    input  logic [15:0]        i_shaded_green,
    input  logic [15:0]        i_shaded_blue,
    input  logic               i_cfg_we,
    input  logic [CFG_AW-1:0]  i_cfg_addr,
    input  logic [CFG_DW-1:0]  i_cfg_wdata,
    output int                 o_errors,
    output int                 o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint UNIT = 16384;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_colour;

    logic [47:0] light_pos, eye_pos, ambient, light_col;
    logic [15:0] kd, ks;
    t_colour     colour_q[$];

    function automatic longint unsigned int_sqrt(input longint unsigned s);
        longint unsigned res, b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s   = s - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint scale_comp(input longint v, input longint unsigned r);
        longint unsigned mag, q;
        if (r == 0) return 0;
        mag = (v < 0) ? -v : v;
        q   = mag * UNIT / r;
        if (q > UNIT) q = UNIT;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic void unit_vec(input longint a, b, c,
                                     output longint ua, ub, uc);
        longint unsigned r;
        r  = int_sqrt(a * a + b * b + c * c);
        ua = scale_comp(a, r);
        ub = scale_comp(b, r);
        uc = scale_comp(c, r);
    endfunction

    function automatic longint lane(input logic [47:0] p, input int i);
        return longint'($signed(p[16*i +: 16]));
    endfunction

    function automatic t_colour shade_pixel(input longint nx, ny, nz, wx, wy, wz,
                                            input logic [15:0] tr, tg, tb);
        longint n0, n1, n2, l0, l1, l2, e0, e1, e2, r0, r1, r2, d, sp;
        longint unsigned diff, spec, term, lit, c;
        logic [15:0] tex [3];
        t_chan       res [3];
        t_colour     col;
        unit_vec(nx, ny, nz, n0, n1, n2);
        unit_vec(wx - lane(light_pos, 0), wy - lane(light_pos, 1),
                 wz - lane(light_pos, 2), l0, l1, l2);
        unit_vec(lane(eye_pos, 0) - wx, lane(eye_pos, 1) - wy,
                 lane(eye_pos, 2) - wz, e0, e1, e2);
        d = (n0 * l0 + n1 * l1 + n2 * l2) >>> 14;
        unit_vec(((2 * d * n0) >>> 14) - l0, ((2 * d * n1) >>> 14) - l1,
                 ((2 * d * n2) >>> 14) - l2, r0, r1, r2);
        diff = (d < 0) ? -d : d;
        if (diff > UNIT) diff = UNIT;
        sp = (e0 * r0 + e1 * r1 + e2 * r2) >>> 14;
        if (sp < 0) sp = 0;
        if (sp > UNIT) sp = UNIT;
        spec = sp;
        repeat (SPEC_SQ) spec = (spec * spec) >> 14;
        term = (diff * kd + spec * ks) >> 10;
        tex = '{tr, tg, tb};
        for (int i = 0; i < 3; i++) begin
            lit = ambient[16*i +: 16] + ((light_col[16*i +: 16] * term) >> 16);
            c   = (tex[i] * lit) >> 16;
            res[i] = (c > 65535) ? 16'hFFFF : c[15:0];
        end
        col.red   = res[0];
        col.green = res[1];
        col.blue  = res[2];
        return col;
    endfunction

    assign o_pending = colour_q.size();

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_colour want;
        if (!i_rst_n) begin
            light_pos <= '0;
            eye_pos   <= '0;
            ambient   <= '0;
            light_col <= '0;
            kd        <= COEF_RESET;
            ks        <= COEF_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_LIGHT_POS: light_pos <= i_cfg_wdata;
                    CFG_EYE_POS:   eye_pos   <= i_cfg_wdata;
                    CFG_AMBIENT:   ambient   <= i_cfg_wdata;
                    CFG_LIGHT_COL: light_col <= i_cfg_wdata;
                    CFG_KD:        kd        <= i_cfg_wdata[15:0];
                    CFG_KS:        ks        <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                colour_q.push_back(shade_pixel(i_normal_x, i_normal_y, i_normal_z,
                                               i_world_x, i_world_y, i_world_z,
                                               i_texel_red, i_texel_green,
                                               i_texel_blue));
            if (i_out_valid && i_out_ready) begin
                if (colour_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10)
                        $display("Unexpected result %h %h %h", i_shaded_red,
                                 i_shaded_green, i_shaded_blue);
                end else begin
                    want = colour_q.pop_front();
                    if (want.red !== i_shaded_red || want.green !== i_shaded_green ||
                        want.blue !== i_shaded_blue) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("Mismatch: expected %h %h %h, got %h %h %h",
                                     want.red, want.green, want.blue, i_shaded_red,
                                     i_shaded_green, i_shaded_blue);
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

### tb/phong_pixel_shading_unit_test.sv
// ----------------------------------------------------------------------------
// Phong pixel shading unit testbench
// Drives directed and random pixels through several register settings and
// flow-control patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module phong_pixel_shading_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import psh_pkg::*;

    localparam int DRAIN_WAIT = PIPE_LAST + 20;
    localparam int STALL_LIMIT = 5000;

    logic               i_clk, i_rst_n;
    logic               in_valid, in_ready, out_valid, out_ready;
    logic signed [15:0] nx, ny, nz, wx, wy, wz;
    logic [15:0]        tr, tg, tb, sr, sg, sb;
    logic               cfg_we;
    logic [CFG_AW-1:0]  cfg_addr;
    logic [CFG_DW-1:0]  cfg_wdata;
    int                 errors, pending, flow_mode, idle_cycles;
    bit                 long_hold;

    phong_pixel_shading_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_normal_x(nx), .i_normal_y(ny), .i_normal_z(nz),
        .i_world_x(wx), .i_world_y(wy), .i_world_z(wz),
        .i_texel_red(tr), .i_texel_green(tg), .i_texel_blue(tb),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_shaded_red(sr), .o_shaded_green(sg), .o_shaded_blue(sb),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata)
    );

    phong_pixel_shading_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_normal_x(nx), .i_normal_y(ny), .i_normal_z(nz),
        .i_world_x(wx), .i_world_y(wy), .i_world_z(wz),
        .i_texel_red(tr), .i_texel_green(tg), .i_texel_blue(tb),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_shaded_red(sr), .i_shaded_green(sg), .i_shaded_blue(sb),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure by phase, plus one long hold-off.
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                out_ready = 1'b0;
                repeat (400) @(negedge i_clk);
                long_hold = 1'b0;
            end
            if (flow_mode == 2)
                out_ready = ($urandom_range(99) >= 70);
            else if (flow_mode == 3)
                out_ready = ($urandom_range(99) >= 6);
            else
                out_ready = 1'b1;
        end
    end

    // Watchdog on cycles without any accepted request or result.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else if (++idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [47:0] data);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic send_pixel(input logic [15:0] a, b, c, d, e, f, r, g, bl);
        if (flow_mode == 1 || flow_mode == 3) begin
            while ($urandom_range(99) < ((flow_mode == 1) ? 70 : 6)) begin
                in_valid = 1'b0;
                @(negedge i_clk);
            end
        end
        in_valid = 1'b1;
        {nx, ny, nz, wx, wy, wz} = {a, b, c, d, e, f};
        {tr, tg, tb} = {r, g, bl};
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
        in_valid = 1'b0;
    endtask

    function automatic logic [15:0] rand_val();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(2048)) - 16'd1024;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random();
        logic [15:0] a, b, c, d, e, f;
        a = rand_val(); b = rand_val(); c = rand_val();
        d = rand_val(); e = rand_val(); f = rand_val();
        send_pixel(a, b, c, d, e, f, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial begin
        in_valid  = 1'b0;
        {nx, ny, nz, wx, wy, wz, tr, tg, tb} = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        flow_mode = 0;
        long_hold = 1'b0;
        i_rst_n   = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed pixels at reset settings; the first has zero-length light and eye vectors.
        send_pixel(16'h4000, '0, '0, '0, '0, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel('0, '0, '0, 16'h7FFF, 16'h8000, '0, 16'h8000, '0, 16'hFFFF);
        wait_drained();
        write_reg(CFG_LIGHT_POS, {16'h0A00, 16'h0500, 16'hFB00});
        write_reg(CFG_EYE_POS, {16'h1000, 16'h0000, 16'h0000});
        write_reg(CFG_AMBIENT, {16'h2000, 16'h4000, 16'hFFFF});
        write_reg(CFG_LIGHT_COL, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_KD, 48'hFFFF);
        write_reg(CFG_KS, 48'hFFFF);
        write_reg(3'd6, 48'h1234_5678_9ABC);
        write_reg(3'd7, 48'hFFFF_FFFF_FFFF);
        send_pixel(16'h4000, '0, '0, '0, '0, '0, 16'hFFFF, 16'h1234, '0);
        send_pixel('0, 16'h4000, '0, '0, '0, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel('0, '0, 16'h4000, '0, '0, '0, 16'h8000, 16'h8000, 16'h8000);
        send_pixel(16'hC000, '0, '0, 16'h0100, '0, '0, 16'hFFFF, '0, 16'h0001);
        send_pixel('0, '0, '0, '0, '0, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // World at the light, then at the eye.
        send_pixel(16'h2D41, 16'h2D41, '0, 16'hFB00, 16'h0500, 16'h0A00,
                   16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h2D41, '0, 16'h2D41, '0, '0, 16'h1000, 16'hFFFF, 16'h7FFF, 16'h0);
        send_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                   16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                   16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h0001, '0, '0, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF,
                   16'h0001, 16'h0002);
        send_pixel('0, 16'hFFFF, '0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hAAAA,
                   16'h5555, 16'hFFFF);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_LIGHT_POS, '0);
                    write_reg(CFG_EYE_POS, '0);
                    write_reg(CFG_AMBIENT, '0);
                    write_reg(CFG_LIGHT_COL, '0);
                    write_reg(CFG_KD, '0);
                    write_reg(CFG_KS, '0);
                end
                1: begin
                    write_reg(CFG_LIGHT_POS, 48'h7FFF_7FFF_7FFF);
                    write_reg(CFG_EYE_POS, 48'h8000_8000_8000);
                    write_reg(CFG_AMBIENT, 48'hFFFF_FFFF_FFFF);
                    write_reg(CFG_LIGHT_COL, 48'hFFFF_FFFF_FFFF);
                    write_reg(CFG_KD, 48'hFFFF);
                    write_reg(CFG_KS, 48'hFFFF);
                end
                default: begin
                    write_reg(CFG_LIGHT_POS, {16'($urandom), 16'($urandom),
                                              16'($urandom)});
                    write_reg(CFG_EYE_POS, {16'($urandom), 16'($urandom),
                                            16'($urandom)});
                    write_reg(CFG_AMBIENT, {16'($urandom_range(16384)),
                                            16'($urandom_range(16384)),
                                            16'($urandom)});
                    write_reg(CFG_LIGHT_COL, {16'($urandom), 16'($urandom),
                                              16'($urandom)});
                    write_reg(CFG_KD, 48'($urandom_range(8192)));
                    write_reg(CFG_KS, 48'($urandom_range(65535)));
                end
            endcase
            flow_mode = ph % 4;
            if (ph == 4) begin
                flow_mode = 0;
                long_hold = 1'b1;
            end
            for (int k = 0; k < 90; k++) begin
                // In one phase the sender waits once, midway, for every outstanding result.
                if (ph == 5 && k == 45)
                    while (pending != 0) @(negedge i_clk);
                send_random();
            end
            in_valid = 1'b0;
            wait_drained();
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
